/* hdl/lncf_pkg.sv */
package lncf_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int BCD_W         = 4 * NUMBER_DIGITS;
    localparam int COL_W         = $clog2(NUMBER_DIGITS + 1);
    localparam int PREFIX_LEN    = NUMBER_DIGITS + 1;
    localparam int MAX_RUN       = PREFIX_LEN + 2;
    localparam int POS_W         = $clog2(MAX_RUN + 1);
    localparam int CFG_INDEX_W   = 3;

    localparam logic [7:0] NL_BYTE     = 8'd10;
    localparam logic [7:0] TAB_BYTE    = 8'd9;
    localparam logic [7:0] DEL_BYTE    = 8'd127;
    localparam logic [7:0] LAST_CTRL   = 8'd31;
    localparam logic [7:0] CARET_OFS   = 8'd64;
    localparam logic [7:0] CARET_BYTE  = 8'h5E;
    localparam logic [7:0] QMARK_BYTE  = 8'h3F;
    localparam logic [7:0] DOLLAR_BYTE = 8'h24;
    localparam logic [7:0] I_BYTE      = 8'h49;
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] ZERO_BYTE   = 8'h30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUMBER_ALL       = 3'd0,
        REG_NUMBER_NONBLANK  = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } cfg_reg_t;

    // One accepted byte's worth of output: optional number prefix, then one or two bytes.
    typedef struct packed {
        logic             has_num;
        logic [BCD_W-1:0] digits;
        logic             two_tail;
        logic [7:0]       tail0;
        logic [7:0]       tail1;
    } job_t;

    function automatic logic [BCD_W-1:0] bcd_bump(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        logic             all_nines;
        logic             carry;
        logic [3:0]       d;
        res       = bcd;
        all_nines = 1'b1;
        carry     = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (bcd[4*i +: 4] != 4'd9) begin
                all_nines = 1'b0;
            end
        end
        if (!all_nines) begin
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                d = bcd[4*i +: 4];
                if (carry) begin
                    if (d >= 4'd9) begin
                        res[4*i +: 4] = 4'd0;
                    end
                    else begin
                        res[4*i +: 4] = d + 4'd1;
                        carry         = 1'b0;
                    end
                end
            end
        end
        return res;
    endfunction

    // Character in column col (0 is the leftmost) of the space-padded number.
    function automatic logic [7:0] number_char(input logic [BCD_W-1:0] bcd,
                                               input logic [COL_W-1:0] col);
        logic [7:0] ch;
        logic       leading;
        logic [3:0] d;
        ch      = SPACE_BYTE;
        leading = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            d = bcd[4*i +: 4];
            if (d > 4'd9) begin
                d = 4'd9;
            end
            if (d == 4'd0 && leading && i > 0) begin
                if (col == COL_W'(NUMBER_DIGITS - 1 - i)) begin
                    ch = SPACE_BYTE;
                end
            end
            else begin
                leading = 1'b0;
                if (col == COL_W'(NUMBER_DIGITS - 1 - i)) begin
                    ch = ZERO_BYTE + {4'd0, d};
                end
            end
        end
        return ch;
    endfunction

endpackage

/* hdl/lncf_emitter.sv */
module lncf_emitter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  lncf_pkg::job_t load_job,
    output logic          busy,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          last_of_run
);

    logic                       job_valid_reg;
    lncf_pkg::job_t             job_reg;
    logic [lncf_pkg::POS_W-1:0] pos_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_last_reg;

    logic                       out_free;
    logic                       move;
    logic                       job_done;
    logic [lncf_pkg::POS_W-1:0] run_len;
    logic [lncf_pkg::POS_W-1:0] tail_pos;
    logic [7:0]                 byte_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign move     = job_valid_reg && out_free;
    assign run_len  = (job_reg.has_num ? lncf_pkg::POS_W'(lncf_pkg::PREFIX_LEN)
                                       : lncf_pkg::POS_W'(0))
                      + (job_reg.two_tail ? lncf_pkg::POS_W'(2) : lncf_pkg::POS_W'(1));
    assign job_done = move && (pos_reg == run_len - lncf_pkg::POS_W'(1));
    assign busy     = job_valid_reg && !job_done;
    assign tail_pos = job_reg.has_num ? pos_reg - lncf_pkg::POS_W'(lncf_pkg::PREFIX_LEN)
                                      : pos_reg;

    always_comb
    begin
        if (job_reg.has_num && pos_reg < lncf_pkg::POS_W'(lncf_pkg::NUMBER_DIGITS)) begin
            byte_next = lncf_pkg::number_char(job_reg.digits,
                                              pos_reg[lncf_pkg::COL_W-1:0]);
        end
        else if (job_reg.has_num &&
                 pos_reg == lncf_pkg::POS_W'(lncf_pkg::NUMBER_DIGITS)) begin
            byte_next = lncf_pkg::TAB_BYTE;
        end
        else if (tail_pos == lncf_pkg::POS_W'(0)) begin
            byte_next = job_reg.tail0;
        end
        else begin
            byte_next = job_reg.tail1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                job_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (job_done) begin
                job_valid_reg <= 1'b0;
            end
            else if (move) begin
                pos_reg <= pos_reg + lncf_pkg::POS_W'(1);
            end
            if (out_free) begin
                out_valid_reg <= move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            job_reg <= load_job;
        end
        if (move) begin
            out_byte_reg <= byte_next;
            out_last_reg <= job_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule

/* hdl/text_line_number_and_caret_filter.sv */
// Text filter: line numbers, blank-line squeezing and caret escapes.
//
// Input channel: data_byte and new_file, one text byte per beat, with
// in_valid and in_stall (driven by this block). Output channel: out_byte and
// last_of_run, with out_valid and out_stall (driven by the receiver);
// last_of_run marks the final output beat caused by one input beat.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data (bit 0 is
// kept); write only while the block is idle. cfg_ready is always high.
//
// The first output beat of an input goes through the job register and then
// the output register. An input that yields n output beats holds the job
// register until the last one moves out, so plain bytes flow at one beat per
// cycle while the receiver does not stall; a numbered line start adds six
// digits and a tab. A dropped blank line yields no output and loads no job.
// When the receiver stalls, the output register holds and the input side
// stalls as soon as the job register cannot drain.
// Reset clears all options, sets the line number to one and the block to
// line start, and empties the pipeline.
module text_line_number_and_caret_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             new_file,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_byte,
    output logic                             last_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lncf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data
);

    logic number_all_reg;
    logic number_nonblank_reg;
    logic squeeze_blank_reg;
    logic show_ends_reg;
    logic show_tabs_reg;
    logic show_nonprinting_reg;

    logic                         at_line_start_reg;
    logic [1:0]                   blank_run_reg;
    logic [lncf_pkg::BCD_W-1:0]   line_number_reg;
    logic                         at_line_start_next;
    logic [1:0]                   blank_run_next;
    logic [lncf_pkg::BCD_W-1:0]   line_number_next;

    logic                         accept;
    logic                         start;
    logic [1:0]                   run_cur;
    logic [lncf_pkg::BCD_W-1:0]   num_cur;
    logic                         blank;
    logic                         drop;
    logic                         do_number;
    logic                         is_ctrl;
    lncf_pkg::job_t               job;

    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign start   = new_file || at_line_start_reg;
    assign run_cur = new_file ? 2'd0 : blank_run_reg;
    assign num_cur = new_file ? lncf_pkg::BCD_W'(1) : line_number_reg;
    assign blank   = (data_byte == lncf_pkg::NL_BYTE);
    assign is_ctrl = data_byte != 8'd0 && data_byte <= lncf_pkg::LAST_CTRL
                     && data_byte != lncf_pkg::NL_BYTE && data_byte != lncf_pkg::TAB_BYTE;

    always_comb
    begin
        blank_run_next = run_cur;
        if (start) begin
            if (blank) begin
                blank_run_next = (run_cur == 2'd3) ? 2'd3 : run_cur + 2'd1;
            end
            else begin
                blank_run_next = 2'd0;
            end
        end
        drop      = squeeze_blank_reg && start && blank_run_next > 2'd1;
        do_number = start && !drop
                    && (number_nonblank_reg ? !blank : number_all_reg);
        line_number_next   = do_number ? lncf_pkg::bcd_bump(num_cur) : num_cur;
        at_line_start_next = blank;

        job.has_num  = do_number;
        job.digits   = num_cur;
        job.two_tail = 1'b1;
        job.tail0    = lncf_pkg::CARET_BYTE;
        job.tail1    = data_byte;
        if (show_tabs_reg && data_byte == lncf_pkg::TAB_BYTE) begin
            job.tail1 = lncf_pkg::I_BYTE;
        end
        else if (show_ends_reg && blank) begin
            job.tail0 = lncf_pkg::DOLLAR_BYTE;
        end
        else if (show_nonprinting_reg && is_ctrl) begin
            job.tail1 = data_byte + lncf_pkg::CARET_OFS;
        end
        else if (show_nonprinting_reg && data_byte == lncf_pkg::DEL_BYTE) begin
            job.tail1 = lncf_pkg::QMARK_BYTE;
        end
        else begin
            job.two_tail = 1'b0;
            job.tail0    = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            number_all_reg       <= 1'b0;
            number_nonblank_reg  <= 1'b0;
            squeeze_blank_reg    <= 1'b0;
            show_ends_reg        <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_nonprinting_reg <= 1'b0;
            at_line_start_reg    <= 1'b1;
            blank_run_reg        <= 2'd0;
            line_number_reg      <= lncf_pkg::BCD_W'(1);
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lncf_pkg::REG_NUMBER_ALL:       number_all_reg       <= cfg_data;
                    lncf_pkg::REG_NUMBER_NONBLANK:  number_nonblank_reg  <= cfg_data;
                    lncf_pkg::REG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_data;
                    lncf_pkg::REG_SHOW_ENDS:        show_ends_reg        <= cfg_data;
                    lncf_pkg::REG_SHOW_TABS:        show_tabs_reg        <= cfg_data;
                    lncf_pkg::REG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                at_line_start_reg <= at_line_start_next;
                blank_run_reg     <= blank_run_next;
                line_number_reg   <= line_number_next;
            end
        end
    end

    lncf_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && !drop),
        .load_job    (job),
        .busy        (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

/* sim/text_line_number_and_caret_filter_tb.sv */
module text_line_number_and_caret_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lncf_pkg::*;

    localparam int     HALF_PERIOD   = 6;
    localparam int     RESET_CYCLES  = 4;
    localparam int     IDLE_PCT      = 32;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 40;
    localparam int     HOLD_AT_BEAT  = 150;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     CALM_IN_LO    = 150;
    localparam int     CALM_IN_HI    = 210;
    localparam int     CALM_OUT_LO   = 300;
    localparam int     CALM_OUT_HI   = 550;
    localparam longint NUMBER_MAX    = 10 ** NUMBER_DIGITS - 1;
    localparam logic [1:0] BLANK_SAT = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] ob;
        logic       last;
    } out_beat_t;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [7:0]             data;
        logic                   nf;
        logic                   typed;
        logic [7:0]             want;
    } dir_row_t;

    localparam int NUM_ROWS = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             data_byte;
    logic                   new_file;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             out_byte;
    logic                   last_of_run;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic                   cfg_data;

    text_line_number_and_caret_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .new_file    (new_file),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Mirror of the filter options and line state.
    logic   opt_all;
    logic   opt_nonblank;
    logic   opt_squeeze;
    logic   opt_ends;
    logic   opt_tabs;
    logic   opt_nonprint;
    logic   at_line_start;
    logic [1:0] blank_count;
    longint line_no;

    out_beat_t pending_beats[$];
    int        mismatches;
    int        bytes_sent;
    int        beats_seen;
    int        hold_left;

    dir_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h00, 1'b0, 1'b1, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'hFF, 1'b0, 1'b1, 8'hFF},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h80, 1'b0, 1'b1, 8'h80},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h7F, 1'b0, 1'b1, 8'h7F},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b1, 8'h0A},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h09, 1'b0, 1'b1, 8'h09},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h01, 1'b0, 1'b1, 8'h01},
        '{ROW_CFG,  REG_NUMBER_ALL,       8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_NUMBER_NONBLANK,  8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SQUEEZE_BLANK,    8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SHOW_ENDS,        8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SHOW_TABS,        8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SHOW_NONPRINTING, 8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SPARE_A,          8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SPARE_B,          8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h61, 1'b1, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h09, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h1F, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h7F, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'hFF, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_NUMBER_NONBLANK,  8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SQUEEZE_BLANK,    8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SHOW_TABS,        8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h09, 1'b1, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SHOW_TABS,        8'h01, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SHOW_NONPRINTING, 8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_NUMBER_ALL,       8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_CFG,  REG_SHOW_ENDS,        8'h00, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h09, 1'b0, 1'b0, 8'h00},
        '{ROW_BYTE, REG_NUMBER_ALL,       8'h0A, 1'b0, 1'b0, 8'h00}
    };

    function automatic void reset_filter_model();
        opt_all       = 1'b0;
        opt_nonblank  = 1'b0;
        opt_squeeze   = 1'b0;
        opt_ends      = 1'b0;
        opt_tabs      = 1'b0;
        opt_nonprint  = 1'b0;
        at_line_start = 1'b1;
        blank_count   = 2'd0;
        line_no       = 1;
    endfunction

    // Works out the bytes one input byte turns into and queues them when keep is set.
    function automatic void predict_filter(input logic [7:0] b, input logic nf, input bit keep);
        logic [7:0] run[$];
        string      digits;
        logic       blank;
        if (nf)
        begin
            at_line_start = 1'b1;
            blank_count   = 2'd0;
            line_no       = 1;
        end
        if (at_line_start)
        begin
            blank = (b == NL_BYTE);
            if (!blank)
                blank_count = 2'd0;
            else if (blank_count < BLANK_SAT)
                blank_count = blank_count + 2'd1;
            if (opt_squeeze && blank_count > 2'd1)
                return;
            if (opt_nonblank ? !blank : opt_all)
            begin
                digits = $sformatf("%0d", line_no);
                for (int k = digits.len(); k < NUMBER_DIGITS; k++)
                    run.push_back(SPACE_BYTE);
                for (int k = 0; k < digits.len(); k++)
                    run.push_back(digits[k]);
                run.push_back(TAB_BYTE);
                if (line_no < NUMBER_MAX)
                    line_no++;
            end
        end
        if (opt_tabs && b == TAB_BYTE)
        begin
            run.push_back(CARET_BYTE);
            run.push_back(I_BYTE);
        end
        else
        begin
            if (opt_ends && b == NL_BYTE)
                run.push_back(DOLLAR_BYTE);
            if (opt_nonprint && b != NL_BYTE && b != TAB_BYTE && b >= 8'd1 && b <= LAST_CTRL)
            begin
                run.push_back(CARET_BYTE);
                run.push_back(b + CARET_OFS);
            end
            else if (opt_nonprint && b == DEL_BYTE)
            begin
                run.push_back(CARET_BYTE);
                run.push_back(QMARK_BYTE);
            end
            else
                run.push_back(b);
        end
        at_line_start = (b == NL_BYTE);
        if (keep)
            foreach (run[i])
                pending_beats.push_back('{run[i], i == run.size() - 1});
    endfunction

    function automatic logic [7:0] random_text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return NL_BYTE;
        else if (pick < 24)
            return TAB_BYTE;
        else if (pick < 34)
            return 8'($urandom_range(0, 31));
        else if (pick < 38)
            return DEL_BYTE;
        else if (pick < 46)
            return 8'($urandom_range(128, 255));
        else
            return 8'($urandom_range(32, 126));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic nf, input bit keep);
        @(negedge clk);
        while (!(bytes_sent >= CALM_IN_LO && bytes_sent < CALM_IN_HI) &&
               $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        new_file  = nf;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        predict_filter(b, nf, keep);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        @(negedge clk);
        in_valid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_NUMBER_ALL:       opt_all      = val;
            REG_NUMBER_NONBLANK:  opt_nonblank = val;
            REG_SQUEEZE_BLANK:    opt_squeeze  = val;
            REG_SHOW_ENDS:        opt_ends     = val;
            REG_SHOW_TABS:        opt_tabs     = val;
            REG_SHOW_NONPRINTING: opt_nonprint = val;
            default:              ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_options(input logic [5:0] bits);
        wait_idle();
        write_reg(REG_NUMBER_ALL,       bits[0]);
        write_reg(REG_NUMBER_NONBLANK,  bits[1]);
        write_reg(REG_SQUEEZE_BLANK,    bits[2]);
        write_reg(REG_SHOW_ENDS,        bits[3]);
        write_reg(REG_SHOW_TABS,        bits[4]);
        write_reg(REG_SHOW_NONPRINTING, bits[5]);
    endtask

    function automatic void check_beat(input logic [7:0] ob, input logic last);
        out_beat_t want;
        if (pending_beats.size() == 0)
        begin
            $display("%0t: unexpected beat: expected none, got out_byte %h last_of_run %b",
                     $time, ob, last);
            mismatches++;
            return;
        end
        want = pending_beats.pop_front();
        if (ob !== want.ob)
        begin
            $display("%0t: out_byte expected %h, got %h", $time, want.ob, ob);
            mismatches++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last_of_run expected %b, got %b", $time, want.last, last);
            mismatches++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin : limit
        #(5ms);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : receiver
        out_stall  = 1'b0;
        beats_seen = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (beats_seen >= CALM_OUT_LO && beats_seen < CALM_OUT_HI)
                out_stall = 1'b0;
            else
                out_stall = ($urandom_range(0, 99) < IDLE_PCT);
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                check_beat(out_byte, last_of_run);
                beats_seen++;
                if (beats_seen == HOLD_AT_BEAT)
                    hold_left = HOLD_CYCLES;
            end
        end
    end

    initial
    begin : stimulus
        logic [5:0] bits;
        int         waited;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'd0;
        new_file   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_NUMBER_ALL;
        cfg_data   = 1'b0;
        mismatches = 0;
        bytes_sent = 0;
        reset_filter_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(directed_rows[r].idx, directed_rows[r].data[0]);
            end
            else if (directed_rows[r].typed)
            begin
                send_byte(directed_rows[r].data, directed_rows[r].nf, 1'b0);
                pending_beats.push_back('{directed_rows[r].want, 1'b1});
            end
            else
                send_byte(directed_rows[r].data, directed_rows[r].nf, 1'b1);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                bits = 6'b000000;
            else if (p == 1)
                bits = 6'b111111;
            else
                bits = 6'($urandom());
            set_options(bits);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_byte(random_text_byte(), ($urandom_range(0, 24) == 0), 1'b1);
        end

        @(negedge clk);
        in_valid = 1'b0;
        waited   = 0;
        while (pending_beats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
            mismatches += pending_beats.size();
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
